@@ rtl/amsms_pkg.sv @@
// ----------------------------------------------------------------------------
// AT modem SMS sequencer package
// Shared types, codes and constants for the sequencer datapath and control.
// ----------------------------------------------------------------------------
package amsms_pkg;

  // Line buffer sizing.
  localparam int unsigned LINE_CAPACITY = 64;
  localparam int unsigned LINE_LEN_W    = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned HEAD_DEPTH    = 5;

  // Operation codes of an input item.
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_SEND = 2'd2;
  localparam logic [1:0] OP_TAKE = 2'd3;

  // Command codes to transmit.
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_AT   = 3'd1;
  localparam logic [2:0] CMD_CMGF = 3'd2;
  localparam logic [2:0] CMD_CSMP = 3'd3;
  localparam logic [2:0] CMD_CMGS = 3'd4;
  localparam logic [2:0] CMD_TEXT = 3'd5;

  // Message outcome codes.
  localparam logic [1:0] OUTC_NONE = 2'd0;
  localparam logic [1:0] OUTC_OK   = 2'd1;
  localparam logic [1:0] OUTC_FAIL = 2'd2;

  // Special characters.
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PROMPT = 8'h3E;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_R      = 8'h52;

  // Configuration register indexes.
  localparam logic [1:0] REG_BOOT_WAIT  = 2'd0;
  localparam logic [1:0] REG_CMD_TMO    = 2'd1;
  localparam logic [1:0] REG_SMS_EN     = 2'd2;
  localparam logic [1:0] REG_TEXT_MAX   = 2'd3;

  typedef logic [1:0] op_t;
  typedef logic [LINE_LEN_W-1:0] line_len_t;

  typedef struct packed {
    logic [31:0] boot_wait_ms;
    logic [31:0] command_timeout_ms;
    logic        sms_enabled;
    logic [7:0]  text_max_length;
  } cfg_t;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic [7:0]  text_length;
  } item_t;

  typedef struct packed {
    logic [2:0] command_code;
    logic       request_accepted;
    logic [1:0] sms_outcome;
    logic       busy_res;
  } result_t;

  // Control from the sequencer to the line buffer.
  typedef struct packed {
    logic clr;
    logic push;
  } line_ctl_t;

  // Match status of the line held in the buffer.
  typedef struct packed {
    logic ok;
    logic err;
  } line_stat_t;

endpackage

@@ rtl/amsms_chan_if.sv @@
// ----------------------------------------------------------------------------
// AT modem SMS sequencer channels
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface amsms_in_if;
  logic             valid;
  logic             ready;
  amsms_pkg::op_t   operation;
  logic [7:0]       rx_byte;
  logic [31:0]      now_ms;
  logic [7:0]       text_length;

  modport source (output valid, operation, rx_byte, now_ms, text_length, input ready);
  modport sink   (input valid, operation, rx_byte, now_ms, text_length, output ready);
endinterface

interface amsms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] command_code;
  logic       request_accepted;
  logic [1:0] sms_outcome;
  logic       busy_res;

  modport source (output valid, command_code, request_accepted, sms_outcome, busy_res,
                  input ready);
  modport sink   (input valid, command_code, request_accepted, sms_outcome, busy_res,
                  output ready);
endinterface

@@ rtl/amsms_line.sv @@
// ----------------------------------------------------------------------------
// AT modem SMS line buffer
// Counts the bytes of the current line, keeps its first five bytes and
// reports whether the line reads OK or ERROR.
// ----------------------------------------------------------------------------
module amsms_line (
  input  logic                 clk,
  input  logic                 rst_n,
  input  amsms_pkg::line_ctl_t ctl,
  input  logic [7:0]           rx_byte,
  output amsms_pkg::line_stat_t stat
);

  amsms_pkg::line_len_t len_r, len_nxt;
  logic [7:0]           head_r [amsms_pkg::HEAD_DEPTH];

  // Length update: clear, append, or clear on overflow.
  always_comb begin
    len_nxt = len_r;
    if (ctl.clr) begin
      len_nxt = '0;
    end else if (ctl.push) begin
      if (len_r < amsms_pkg::line_len_t'(amsms_pkg::LINE_CAPACITY)) begin
        len_nxt = len_r + 1'b1;
      end else begin
        len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  // Head bytes are written in place; only the first five bytes are kept.
  always_ff @(posedge clk) begin
    for (int i = 0; i < amsms_pkg::HEAD_DEPTH; i++) begin
      if (!ctl.clr && ctl.push && len_r == amsms_pkg::line_len_t'(i)) begin
        head_r[i] <= rx_byte;
      end
    end
  end

  // Line matching.
  always_comb begin
    stat.ok  = (len_r == amsms_pkg::line_len_t'(2)) &&
               head_r[0] == amsms_pkg::CH_O && head_r[1] == amsms_pkg::CH_K;
    stat.err = (len_r == amsms_pkg::line_len_t'(5)) &&
               head_r[0] == amsms_pkg::CH_E && head_r[1] == amsms_pkg::CH_R &&
               head_r[2] == amsms_pkg::CH_R && head_r[3] == amsms_pkg::CH_O &&
               head_r[4] == amsms_pkg::CH_R;
  end

endmodule

@@ rtl/amsms_ctrl.sv @@
// ----------------------------------------------------------------------------
// AT modem SMS sequence control
// State machine for boot wait, AT probe and the CMGF/CSMP/CMGS/result
// sequence, with phase timer, timeouts and the stored outcome.
// ----------------------------------------------------------------------------
module amsms_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  amsms_pkg::item_t      item,
  input  amsms_pkg::cfg_t       cfg,
  input  amsms_pkg::line_stat_t stat,
  output amsms_pkg::line_ctl_t  line_ctl,
  output amsms_pkg::result_t    res
);

  localparam logic [2:0] ST_BOOT   = 3'd0;
  localparam logic [2:0] ST_AT     = 3'd1;
  localparam logic [2:0] ST_READY  = 3'd2;
  localparam logic [2:0] ST_CMGF   = 3'd3;
  localparam logic [2:0] ST_CSMP   = 3'd4;
  localparam logic [2:0] ST_PROMPT = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic [1:0]  outc_r, outc_nxt;
  logic [31:0] elapsed;
  logic        busy_cur;
  logic        clr, push;
  logic        send_ok;

  assign elapsed  = item.now_ms - phase_r;
  assign busy_cur = (state_r >= ST_CMGF) && (state_r <= ST_RESULT);
  assign send_ok  = cfg.sms_enabled && (state_r == ST_READY) &&
                    (item.text_length != 8'd0) &&
                    (item.text_length <= cfg.text_max_length);

  // Next state for the item in the input register.
  always_comb begin
    state_nxt            = state_r;
    phase_nxt            = phase_r;
    outc_nxt             = outc_r;
    clr                  = 1'b0;
    push                 = 1'b0;
    res.command_code     = amsms_pkg::CMD_NONE;
    res.request_accepted = 1'b0;
    unique case (item.operation)
      amsms_pkg::OP_BYTE: begin
        if (item.rx_byte == amsms_pkg::CH_PROMPT && state_r == ST_PROMPT) begin
          state_nxt        = ST_RESULT;
          phase_nxt        = item.now_ms;
          clr              = 1'b1;
          res.command_code = amsms_pkg::CMD_TEXT;
        end else if (item.rx_byte == amsms_pkg::CH_LF) begin
          clr = 1'b1;
          if (stat.err) begin
            if (busy_cur) begin
              state_nxt = ST_READY;
              outc_nxt  = amsms_pkg::OUTC_FAIL;
            end
          end else if (stat.ok) begin
            priority case (state_r)
              ST_AT: begin
                state_nxt = ST_READY;
              end
              ST_CMGF: begin
                state_nxt        = ST_CSMP;
                phase_nxt        = item.now_ms;
                res.command_code = amsms_pkg::CMD_CSMP;
              end
              ST_CSMP: begin
                state_nxt        = ST_PROMPT;
                phase_nxt        = item.now_ms;
                res.command_code = amsms_pkg::CMD_CMGS;
              end
              ST_RESULT: begin
                state_nxt = ST_READY;
                outc_nxt  = amsms_pkg::OUTC_OK;
              end
              default: begin
                state_nxt = state_r;
              end
            endcase
          end
        end else if (item.rx_byte != amsms_pkg::CH_CR) begin
          push = 1'b1;
        end
      end
      amsms_pkg::OP_TICK: begin
        if (state_r == ST_BOOT && elapsed >= cfg.boot_wait_ms) begin
          state_nxt        = ST_AT;
          phase_nxt        = item.now_ms;
          clr              = 1'b1;
          res.command_code = amsms_pkg::CMD_AT;
        end else if ((state_r == ST_AT || busy_cur) &&
                     elapsed >= cfg.command_timeout_ms) begin
          if (state_r == ST_AT) begin
            state_nxt = ST_BOOT;
            phase_nxt = item.now_ms;
          end else begin
            state_nxt = ST_READY;
            outc_nxt  = amsms_pkg::OUTC_FAIL;
            clr       = 1'b1;
          end
        end
      end
      amsms_pkg::OP_SEND: begin
        if (send_ok) begin
          outc_nxt             = amsms_pkg::OUTC_NONE;
          state_nxt            = ST_CMGF;
          phase_nxt            = item.now_ms;
          clr                  = 1'b1;
          res.command_code     = amsms_pkg::CMD_CMGF;
          res.request_accepted = 1'b1;
        end
      end
      amsms_pkg::OP_TAKE: begin
        outc_nxt = amsms_pkg::OUTC_NONE;
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
    // A consume reports the outcome held before it clears it.
    res.sms_outcome = (item.operation == amsms_pkg::OP_TAKE) ? outc_r : outc_nxt;
    res.busy_res    = (state_nxt >= ST_CMGF) && (state_nxt <= ST_RESULT);
  end

  assign line_ctl.clr  = fire && clr;
  assign line_ctl.push = fire && push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_BOOT;
      phase_r <= '0;
      outc_r  <= amsms_pkg::OUTC_NONE;
    end else if (fire) begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      outc_r  <= outc_nxt;
    end
  end

endmodule

@@ rtl/at_modem_sms_sequencer.sv @@
// ----------------------------------------------------------------------------
// AT modem SMS sequencer
// Drives an AT-command modem through boot wait, probe, CMGF, CSMP, CMGS
// prompt and result, one input item per cycle unless the result side stalls.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, and its result is
// registered in the result register; a stall holds the item in the input stage.
// Throughput: one item per cycle while the result is taken; the sequence state
// updates in one pass between the input register and the result register.
// Reset: synchronous active-low; the machine enters boot wait with the phase
// timer at zero, an empty line, no stored outcome and registers at defaults.
module at_modem_sms_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  amsms_in_if.sink          in_ch,
  amsms_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [31:0]       cfg_wdata
);

  amsms_pkg::cfg_t       cfg_r;
  amsms_pkg::item_t      s1_r;
  logic                  s1_v_r, s1_v_nxt;
  amsms_pkg::result_t    out_r, res;
  logic                  out_v_r, out_v_nxt;
  logic                  adv, fire, in_acc;
  amsms_pkg::line_ctl_t  line_ctl;
  amsms_pkg::line_stat_t line_stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boot_wait_ms       <= 32'd3000;
      cfg_r.command_timeout_ms <= 32'd5000;
      cfg_r.sms_enabled        <= 1'b1;
      cfg_r.text_max_length    <= 8'd160;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        amsms_pkg::REG_BOOT_WAIT: cfg_r.boot_wait_ms       <= cfg_wdata;
        amsms_pkg::REG_CMD_TMO:   cfg_r.command_timeout_ms <= cfg_wdata;
        amsms_pkg::REG_SMS_EN:    cfg_r.sms_enabled        <= cfg_wdata[0];
        amsms_pkg::REG_TEXT_MAX:  cfg_r.text_max_length    <= cfg_wdata[7:0];
        default:                  cfg_r                    <= cfg_r;
      endcase
    end
  end

  // Handshake: the result register frees the input stage when taken.
  assign adv         = !out_v_r || out_ch.ready;
  assign fire        = s1_v_r && adv;
  assign in_ch.ready = !s1_v_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s1_v_nxt    = in_acc ? 1'b1 : (fire ? 1'b0 : s1_v_r);
  assign out_v_nxt   = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Input item register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.operation   <= in_ch.operation;
      s1_r.rx_byte     <= in_ch.rx_byte;
      s1_r.now_ms      <= in_ch.now_ms;
      s1_r.text_length <= in_ch.text_length;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  amsms_line u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (line_ctl),
    .rx_byte (s1_r.rx_byte),
    .stat    (line_stat)
  );

  amsms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (s1_r),
    .cfg      (cfg_r),
    .stat     (line_stat),
    .line_ctl (line_ctl),
    .res      (res)
  );

  assign out_ch.valid            = out_v_r;
  assign out_ch.command_code     = out_r.command_code;
  assign out_ch.request_accepted = out_r.request_accepted;
  assign out_ch.sms_outcome      = out_r.sms_outcome;
  assign out_ch.busy_res         = out_r.busy_res;

  // An accepted request always issues CMGF and leaves the machine busy.
  a_accept_cmgf: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.request_accepted |->
      out_ch.command_code == amsms_pkg::CMD_CMGF && out_ch.busy_res)
    else $error("accepted request without CMGF or busy");

  // A held input item is not lost while the result side stalls.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r)
    else $error("input stage dropped an item during a stall");

  // The stored outcome never takes an undefined code.
  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.sms_outcome != 2'd3)
    else $error("undefined outcome code");

  // The line buffer is only told to clear or append when an item fires.
  a_line_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    (line_ctl.clr || line_ctl.push) |-> fire)
    else $error("line buffer updated without an item");

endmodule
